@@ rtl/pfem_pkg.sv @@
package pfem_pkg;

  // Time base of the tick input, in hertz (1 to 100000)
  localparam int unsigned TickHz = 1000;
  // Widths sized for the largest supported tick rate
  localparam int unsigned TickW  = 17;
  localparam int unsigned ProdW  = 32 + TickW;  // pulses * TickHz
  localparam int unsigned WideW  = ProdW + 32;  // pulses * TickHz * cal
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = 5;           // 32 quotient bits

  // Register reset values
  localparam logic [31:0] VoltageCalRst = 32'd8686;
  localparam logic [31:0] CurrentCalRst = 32'd777;
  localparam logic [31:0] PowerCalRst   = 32'd98304;
  localparam logic [12:0] PowerMaxRst   = 13'd3680;
  localparam logic [15:0] MinWindowRst  = 16'd500;
  localparam logic [15:0] SettleRst     = 16'd1000;

  typedef enum logic [2:0] {
    REG_VOLTAGE_CAL,
    REG_CURRENT_CAL,
    REG_POWER_CAL,
    REG_POWER_MAX,
    REG_INVERT_SEL,
    REG_MIN_WINDOW,
    REG_SETTLE
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] voltage_cal;
    logic [31:0] current_cal;
    logic [31:0] power_cal;
    logic [12:0] power_max;
    logic        invert_sel;
    logic [15:0] min_window_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] pulses;
    logic [31:0] cal;
    logic [31:0] ticks;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } md_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POWER,
    ST_VC,
    ST_OUT
  } meter_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL0,
    MD_MUL1,
    MD_MUL2,
    MD_ADD,
    MD_CHK,
    MD_DIV,
    MD_DONE
  } md_state_e;

  // A window register of zero behaves as one
  function automatic logic [31:0] window_floor(input logic [15:0] v);
    window_floor = (v == '0) ? 32'd1 : {16'b0, v};
  endfunction

endpackage

@@ rtl/pfem_in_if.sv @@
interface pfem_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic cf_edge;
  logic cf1_edge;
  logic evaluate;

  modport source (output valid, tick, cf_edge, cf1_edge, evaluate, input ready);
  modport sink (input valid, tick, cf_edge, cf1_edge, evaluate, output ready);
endinterface

@@ rtl/pfem_out_if.sv @@
interface pfem_out_if;
  logic        valid;
  logic        ready;
  logic        sel_level;
  logic        publish;
  logic [31:0] power;
  logic [31:0] voltage;
  logic        voltage_valid;
  logic [31:0] current;
  logic        current_valid;
  logic [31:0] interval_ticks;

  modport source (
    output valid, sel_level, publish, power, voltage, voltage_valid,
           current, current_valid, interval_ticks,
    input  ready
  );
  modport sink (
    input  valid, sel_level, publish, power, voltage, voltage_valid,
           current, current_valid, interval_ticks,
    output ready
  );
endinterface

@@ rtl/pfem_cfg.sv @@
module pfem_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfem_pkg::AddrW-1:0]   paddr,
  input  logic [pfem_pkg::DataW-1:0]   pwdata,
  output logic [pfem_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output pfem_pkg::cfg_t               cfg_o
);
  import pfem_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_cal      <= VoltageCalRst;
      cfg_q.current_cal      <= CurrentCalRst;
      cfg_q.power_cal        <= PowerCalRst;
      cfg_q.power_max        <= PowerMaxRst;
      cfg_q.invert_sel       <= 1'b0;
      cfg_q.min_window_ticks <= MinWindowRst;
      cfg_q.settle_ticks     <= SettleRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_VOLTAGE_CAL: cfg_q.voltage_cal      <= pwdata;
        REG_CURRENT_CAL: cfg_q.current_cal      <= pwdata;
        REG_POWER_CAL:   cfg_q.power_cal        <= pwdata;
        REG_POWER_MAX:   cfg_q.power_max        <= pwdata[12:0];
        REG_INVERT_SEL:  cfg_q.invert_sel       <= pwdata[0];
        REG_MIN_WINDOW:  cfg_q.min_window_ticks <= pwdata[15:0];
        REG_SETTLE:      cfg_q.settle_ticks     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOLTAGE_CAL: prdata = cfg_q.voltage_cal;
      REG_CURRENT_CAL: prdata = cfg_q.current_cal;
      REG_POWER_CAL:   prdata = cfg_q.power_cal;
      REG_POWER_MAX:   prdata = {19'b0, cfg_q.power_max};
      REG_INVERT_SEL:  prdata = {31'b0, cfg_q.invert_sel};
      REG_MIN_WINDOW:  prdata = {16'b0, cfg_q.min_window_ticks};
      REG_SETTLE:      prdata = {16'b0, cfg_q.settle_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/pfem_muldiv.sv @@
module pfem_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfem_pkg::md_req_t req_i,
  output pfem_pkg::md_rsp_t rsp_o
);
  import pfem_pkg::*;

  md_state_e         state_q, state_d;
  logic [31:0]       pulses_q, cal_q, ticks_q;
  logic [63:0]       prod_q;
  logic [TickW-1:0]  p_hi_q;
  logic [WideW-1:0]  wide_q;
  logic [31:0]       rem_q;
  logic [31:0]       res_q;
  logic [StepW-1:0]  cnt_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        ovf;
  logic [32:0] trial, diff;
  logic        qbit;

  assign mul_p = mul_a * mul_b;
  // quotient needs more than 32 bits
  assign ovf   = wide_q[WideW-1:32] >= ProdW'(ticks_q);
  assign trial = {rem_q, wide_q[31]};
  assign diff  = trial - {1'b0, ticks_q};
  assign qbit  = trial >= {1'b0, ticks_q};

  // next state; a new request may follow directly on done
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_MUL0;
      MD_MUL0: state_d = MD_MUL1;
      MD_MUL1: state_d = MD_MUL2;
      MD_MUL2: state_d = MD_ADD;
      MD_ADD:  state_d = MD_CHK;
      MD_CHK:  state_d = ovf ? MD_DONE : MD_DIV;
      MD_DIV:  if (&cnt_q) state_d = MD_DONE;
      MD_DONE: state_d = req_i.start ? MD_MUL0 : MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // shared multiplier operands and response
  always_comb begin
    mul_a = '0;
    mul_b = cal_q;
    unique case (state_q)
      MD_MUL0: begin
        mul_a = pulses_q;
        mul_b = 32'(TickHz);
      end
      MD_MUL1: mul_a = prod_q[31:0];
      MD_MUL2: mul_a = 32'(p_hi_q);
      default: ;
    endcase
    rsp_o.done  = (state_q == MD_DONE);
    rsp_o.value = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MD_CHK) cnt_q <= '0;
      else if (state_q == MD_DIV) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE, MD_DONE: if (req_i.start) begin
        pulses_q <= req_i.pulses;
        cal_q    <= req_i.cal;
        ticks_q  <= req_i.ticks;
      end
      MD_MUL0: prod_q <= mul_p;
      MD_MUL1: begin
        p_hi_q <= prod_q[ProdW-1:32];
        prod_q <= mul_p;
      end
      MD_MUL2: begin
        wide_q <= WideW'(prod_q);
        prod_q <= mul_p;
      end
      MD_ADD: wide_q <= wide_q + {prod_q[ProdW-1:0], 32'b0};
      MD_CHK: begin
        rem_q <= wide_q[63:32];
        if (ovf) res_q <= '1;
      end
      MD_DIV: begin
        rem_q        <= qbit ? diff[31:0] : trial[31:0];
        wide_q[31:0] <= {wide_q[30:0], qbit};
        if (&cnt_q) res_q <= {wide_q[30:0], qbit};
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == MD_IDLE || state_q == MD_DONE))
    else $error("muldiv started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MD_DIV |-> rem_q < ticks_q) else $error("remainder out of range");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MD_CHK && ovf) |=> (rsp_o.done && res_q == '1))
    else $error("overflow not saturated");

endmodule

@@ rtl/pulse_frequency_energy_meter.sv @@
// A word without evaluate goes from IDLE straight to OUT; one with a window still too short
// passes IDLE, CHECK, OUT. An evaluate that publishes power runs the shared multiply-divide
// unit once: three multiplier passes, one add, a range check, 32 restoring-divide steps
// (skipped on saturation). If the voltage/current window also closes, it runs a second time.
// Throughput: one word at a time; ready is high only while the sequencer is idle.
// Reset (rst_ni low, async): counters, windows and readings clear, settling and select = 1.
module pulse_frequency_energy_meter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pfem_in_if.sink                    in_i,
  pfem_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfem_pkg::AddrW-1:0] paddr,
  input  logic [pfem_pkg::DataW-1:0] pwdata,
  output logic [pfem_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import pfem_pkg::*;

  cfg_t    cfg;
  md_req_t md_req;
  md_rsp_t md_rsp;

  pfem_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one multiply-divide unit, shared by the power and voltage/current rates
  pfem_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  meter_state_e state_q, state_d;

  // free-running wrapping counters
  logic [31:0] time_count_q, power_pulse_count_q, vc_pulse_count_q;
  // window start marks
  logic [31:0] pw_tick_q, pw_count_q, vc_tick_q, vc_count_q;
  logic        settling_q, sel_state_q, is_volt_q;
  logic [31:0] last_power_q, voltage_q, current_q;
  logic        voltage_known_q, current_known_q;
  logic        publish_q;
  logic [31:0] interval_q;

  // output word register
  logic        out_valid_q;
  logic        out_sel_q, out_publish_q, out_vvalid_q, out_cvalid_q;
  logic [31:0] out_power_q, out_voltage_q, out_current_q, out_interval_q;

  logic [31:0] min_win, settle, elapsed, cf1_ticks;
  logic        win_ok, settle_ok, vc_ok, use_volt;
  logic        in_fire, out_load, power_ok;

  assign min_win   = window_floor(cfg.min_window_ticks);
  assign settle    = window_floor(cfg.settle_ticks);
  assign elapsed   = time_count_q - pw_tick_q;
  assign cf1_ticks = time_count_q - vc_tick_q;
  assign win_ok    = elapsed >= min_win;
  assign settle_ok = cf1_ticks >= settle;
  assign vc_ok     = cf1_ticks >= min_win;
  // select level that means voltage depends on pin polarity
  assign use_volt  = sel_state_q != cfg.invert_sel;
  // readings above the limit keep the last good power
  assign power_ok  = md_rsp.value <= {3'b0, cfg.power_max, 16'b0};

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = in_i.evaluate ? ST_CHECK : ST_OUT;
      ST_CHECK: state_d = win_ok ? ST_POWER : ST_OUT;
      ST_POWER: if (md_rsp.done) state_d = (!settling_q && vc_ok) ? ST_VC : ST_OUT;
      ST_VC:    if (md_rsp.done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit requests: power rate from CHECK, voltage/current rate once power is done
  always_comb begin
    md_req = '0;
    unique case (state_q)
      ST_CHECK: begin
        md_req.start  = win_ok;
        md_req.pulses = power_pulse_count_q - pw_count_q;
        md_req.cal    = cfg.power_cal;
        md_req.ticks  = elapsed;
      end
      ST_POWER: begin
        md_req.start  = md_rsp.done && !settling_q && vc_ok;
        md_req.pulses = vc_pulse_count_q - vc_count_q;
        md_req.cal    = use_volt ? cfg.voltage_cal : cfg.current_cal;
        md_req.ticks  = cf1_ticks;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_IDLE;
      time_count_q        <= '0;
      power_pulse_count_q <= '0;
      vc_pulse_count_q    <= '0;
      pw_tick_q           <= '0;
      pw_count_q          <= '0;
      vc_tick_q           <= '0;
      vc_count_q          <= '0;
      settling_q          <= 1'b1;
      sel_state_q         <= 1'b1;
      last_power_q        <= '0;
      voltage_q           <= '0;
      current_q           <= '0;
      voltage_known_q     <= 1'b0;
      current_known_q     <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        time_count_q        <= time_count_q + 32'(in_i.tick);
        power_pulse_count_q <= power_pulse_count_q + 32'(in_i.cf_edge);
        vc_pulse_count_q    <= vc_pulse_count_q + 32'(in_i.cf1_edge);
      end
      // rebase the power window as soon as the rate is launched
      if (state_q == ST_CHECK && win_ok) begin
        pw_tick_q  <= time_count_q;
        pw_count_q <= power_pulse_count_q;
      end
      if (state_q == ST_POWER && md_rsp.done) begin
        if (power_ok) last_power_q <= md_rsp.value;
        if (settling_q && settle_ok) begin
          // settle time over: open a measurement window
          vc_count_q <= vc_pulse_count_q;
          vc_tick_q  <= time_count_q;
          settling_q <= 1'b0;
        end
      end
      if (state_q == ST_VC && md_rsp.done) begin
        if (is_volt_q) begin
          voltage_q       <= md_rsp.value;
          voltage_known_q <= 1'b1;
        end else begin
          current_q       <= md_rsp.value;
          current_known_q <= 1'b1;
        end
        // flip the select pin and discard the next settle window
        sel_state_q <= ~sel_state_q;
        vc_tick_q   <= time_count_q;
        settling_q  <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // per-word payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      publish_q  <= 1'b0;
      interval_q <= '0;
    end
    if (state_q == ST_CHECK && win_ok) begin
      publish_q  <= 1'b1;
      interval_q <= elapsed;
    end
    if (state_q == ST_POWER && md_rsp.done) is_volt_q <= use_volt;
    if (out_load) begin
      out_sel_q      <= sel_state_q;
      out_publish_q  <= publish_q;
      out_power_q    <= last_power_q;
      out_voltage_q  <= voltage_q;
      out_vvalid_q   <= voltage_known_q;
      out_current_q  <= current_q;
      out_cvalid_q   <= current_known_q;
      out_interval_q <= interval_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sel_level      = out_sel_q;
  assign out_o.publish        = out_publish_q;
  assign out_o.power          = out_power_q;
  assign out_o.voltage        = out_voltage_q;
  assign out_o.voltage_valid  = out_vvalid_q;
  assign out_o.current        = out_current_q;
  assign out_o.current_valid  = out_cvalid_q;
  assign out_o.interval_ticks = out_interval_q;

  a_rebase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POWER && md_rsp.done) |-> pw_tick_q == time_count_q)
    else $error("power window not rebased");

  a_publish_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.publish) |-> out_o.interval_ticks != '0)
    else $error("published word with empty interval");

  a_sel_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sel_state_q) |-> settling_q)
    else $error("select changed without settle");

endmodule
